### design/mvm_pkg.sv
// Shared types and constants for the matrix-vector multiplier.
// Used by every module in design/; depends on nothing.
package mvm_pkg;

  localparam int DEF_MAX_ROWS = 16;
  localparam int DEF_MAX_COLS = 16;
  localparam int RESULT_CAP   = 16;
  localparam int CNT_W        = 5;
  localparam int IDX_W        = 4;
  localparam int VAL_W        = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 5;
  localparam int PROD_W       = 2 * VAL_W;
  localparam int FRAC_W       = 16;
  localparam int ACC_W        = PROD_W - FRAC_W + CNT_W;

  localparam logic [CNT_W-1:0]     CNT_RESET = CNT_W'(RESULT_CAP);
  localparam logic [CFG_IDX_W-1:0] REG_ROWS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COLS  = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    KIND_MAT = 2'd0,
    KIND_VEC = 2'd1,
    KIND_MUL = 2'd2
  } kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } bk_state_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_row;
    logic signed [VAL_W-1:0] dot_sum;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    kind_t                   op;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic [CNT_W-1:0]        nr;
    logic [CNT_W-1:0]        nc;
  } cmd_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [1:0] count;
  } q_stat_t;

endpackage

### design/matrix_vector_multiply.sv
// Matrix-vector multiplier, signed Q16.16 (top level).
// Instantiates mvm_front, mvm_queue and mvm_back; depends on mvm_pkg.
//
// Loads write one matrix or vector element; a compute beat (kind 2) returns
// one saturated dot product per row in use, in row order, last row flagged.
// A beat is taken when start is high and busy is low; busy rises only when
// the two-entry command queue is full. The back end retires a load as it pops
// it and a compute in rows x cols matrix store reads, one per cycle; each row's
// result passes the read, product, accumulator and output registers in turn.
// Results are strobed by out_valid for one cycle and cannot be held off.
// Config writes are always ready and should be issued only while idle.
module matrix_vector_multiply #(
  parameter int MAX_ROWS = mvm_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = mvm_pkg::DEF_MAX_COLS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  mvm_pkg::in_item_t              in_data,
  output logic                           out_valid,
  output mvm_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mvm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mvm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mvm_pkg::*;

  logic    push, pop;
  cmd_t    push_cmd, head;
  q_stat_t q_stat;

  mvm_front #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_data  (in_data),
    .busy     (busy),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  mvm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .stat    (q_stat)
  );

  mvm_back #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_data (out_data)
  );

`ifndef ASSERT_OFF
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count != 2'd3)
    else $error("command queue count out of range");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_stat.count != 2'd0)
    else $error("pop from empty command queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("push into full command queue");

  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(out_valid) && !$past(out_data.last))
      |-> out_data.out_row == $past(out_data.out_row) + 4'd1)
    else $error("results out of row order");
`endif

endmodule

### design/mvm_front.sv
// Front end: config registers, item accept, range checks and count clamping.
// Pushes valid commands into mvm_queue. Depends on mvm_pkg.
module mvm_front #(
  parameter int MAX_ROWS = mvm_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = mvm_pkg::DEF_MAX_COLS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  mvm_pkg::in_item_t                in_data,
  output logic                             busy,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mvm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mvm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  mvm_pkg::q_stat_t                 q_stat,
  output logic                             push,
  output mvm_pkg::cmd_t                    push_cmd
);
  import mvm_pkg::*;

  localparam int RowLim = (MAX_ROWS < RESULT_CAP) ? MAX_ROWS : RESULT_CAP;
  localparam int ColLim = (MAX_COLS < RESULT_CAP) ? MAX_COLS : RESULT_CAP;

  logic [CNT_W-1:0] rows_r, rows_nxt;
  logic [CNT_W-1:0] cols_r, cols_nxt;
  logic             accept, row_ok, col_ok;

  assign cfg_ready = 1'b1;
  assign busy      = q_stat.full;
  assign accept    = start && !busy;
  assign row_ok    = int'(in_data.row_index) < MAX_ROWS;
  assign col_ok    = int'(in_data.col_index) < MAX_COLS;

  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROWS: rows_nxt = CNT_W'(cfg_data);
        REG_COLS: cols_nxt = CNT_W'(cfg_data);
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= CNT_RESET;
      cols_r <= CNT_RESET;
    end else begin
      rows_r <= rows_nxt;
      cols_r <= cols_nxt;
    end
  end

  always_comb begin
    case (in_data.kind)
      KIND_MAT: push = accept && row_ok && col_ok;
      KIND_VEC: push = accept && col_ok;
      KIND_MUL: push = accept;
      default:  push = 1'b0;
    endcase
    push_cmd.op    = kind_t'(in_data.kind);
    push_cmd.row   = in_data.row_index;
    push_cmd.col   = in_data.col_index;
    push_cmd.value = in_data.value;
    if (rows_r == '0) begin
      push_cmd.nr = CNT_W'(1);
    end else if (int'(rows_r) > RowLim) begin
      push_cmd.nr = CNT_W'(RowLim);
    end else begin
      push_cmd.nr = rows_r;
    end
    if (cols_r == '0) begin
      push_cmd.nc = CNT_W'(1);
    end else if (int'(cols_r) > ColLim) begin
      push_cmd.nc = CNT_W'(ColLim);
    end else begin
      push_cmd.nc = cols_r;
    end
  end

endmodule

### design/mvm_queue.sv
// Two-entry command queue between front and back ends.
// Depends on mvm_pkg.
module mvm_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mvm_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output mvm_pkg::cmd_t    head,
  output mvm_pkg::q_stat_t stat
);
  import mvm_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign head       = slot_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.full  = count_r == 2'd2;
  assign stat.empty = count_r == 2'd0;
  assign count_nxt  = count_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_nxt;
    end
  end

endmodule

### design/mvm_back.sv
// Back end: matrix and vector stores, row/column sequencer and MAC pipeline
// (read, multiply, accumulate, saturate). Depends on mvm_pkg.
module mvm_back #(
  parameter int MAX_ROWS = mvm_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = mvm_pkg::DEF_MAX_COLS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mvm_pkg::q_stat_t   q_stat,
  input  mvm_pkg::cmd_t      head,
  output logic               pop,
  output logic               out_valid,
  output mvm_pkg::out_item_t out_data
);
  import mvm_pkg::*;

  localparam int Depth = MAX_ROWS * MAX_COLS;
  localparam int Aw    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int Vw    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  typedef struct packed {
    logic             first;
    logic             lastc;
    logic [IDX_W-1:0] row;
    logic             lastr;
  } tag_t;

  logic signed [VAL_W-1:0] mat_mem [Depth];
  logic signed [VAL_W-1:0] vec_mem [MAX_COLS];

  bk_state_t        state_r, state_nxt;
  logic [IDX_W-1:0] row_r, row_nxt, col_r, col_nxt;
  logic [Aw-1:0]    base_r, base_nxt;
  logic [CNT_W-1:0] nr_r, nr_nxt, nc_r, nc_nxt;

  logic          ld_mat, ld_vec, issue, col_end, row_end;
  logic [Aw-1:0] ld_addr, rd_addr;

  logic signed [VAL_W-1:0]  mat_q_r, vec_q_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic                     s1_v_r, s2_v_r, s3_v_r, out_v_r;
  tag_t                     s1_tag_r, s2_tag_r, s3_tag_r;
  out_item_t                out_r;
  logic [ACC_W-VAL_W:0]     acc_hi;

  assign pop     = (state_r == BK_IDLE) && !q_stat.empty;
  assign ld_mat  = pop && (head.op == KIND_MAT);
  assign ld_vec  = pop && (head.op == KIND_VEC);
  assign ld_addr = Aw'(int'(head.row) * MAX_COLS + int'(head.col));
  assign issue   = state_r == BK_RUN;
  assign rd_addr = base_r + Aw'(col_r);
  assign col_end = ({1'b0, col_r} + CNT_W'(1)) == nc_r;
  assign row_end = ({1'b0, row_r} + CNT_W'(1)) == nr_r;

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    base_nxt  = base_r;
    nr_nxt    = nr_r;
    nc_nxt    = nc_r;
    case (state_r)
      BK_IDLE: begin
        if (pop && head.op == KIND_MUL) begin
          state_nxt = BK_RUN;
          row_nxt   = '0;
          col_nxt   = '0;
          base_nxt  = '0;
          nr_nxt    = head.nr;
          nc_nxt    = head.nc;
        end
      end
      BK_RUN: begin
        if (col_end) begin
          col_nxt  = '0;
          row_nxt  = row_r + IDX_W'(1);
          base_nxt = base_r + Aw'(MAX_COLS);
          if (row_end) begin
            state_nxt = BK_IDLE;
          end
        end else begin
          col_nxt = col_r + IDX_W'(1);
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      row_r   <= '0;
      col_r   <= '0;
      base_r  <= '0;
      nr_r    <= CNT_W'(1);
      nc_r    <= CNT_W'(1);
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      base_r  <= base_nxt;
      nr_r    <= nr_nxt;
      nc_r    <= nc_nxt;
    end
  end

  // stores: loads write only while idle; reads happen every cycle but count only while running
  always_ff @(posedge clk) begin
    if (ld_mat) mat_mem[ld_addr] <= head.value;
    if (ld_vec) vec_mem[Vw'(head.col)] <= head.value;
    mat_q_r <= mat_mem[rd_addr];
    vec_q_r <= vec_mem[Vw'(col_r)];
  end

  assign acc_nxt = (s2_tag_r.first ? ACC_W'(0) : acc_r)
                 + ACC_W'($signed(prod_r[PROD_W-1:FRAC_W]));
  assign acc_hi  = acc_r[ACC_W-1:VAL_W-1];

  always_ff @(posedge clk) begin
    s1_tag_r <= '{first: col_r == '0, lastc: col_end, row: row_r, lastr: row_end};
    prod_r   <= mat_q_r * vec_q_r;
    s2_tag_r <= s1_tag_r;
    if (s2_v_r) begin
      acc_r    <= acc_nxt;
      s3_tag_r <= s2_tag_r;
    end
    out_r.out_row <= s3_tag_r.row;
    out_r.last    <= s3_tag_r.lastr;
    if (&acc_hi || ~|acc_hi) begin
      out_r.dot_sum <= acc_r[VAL_W-1:0];
    end else if (acc_r[ACC_W-1]) begin
      out_r.dot_sum <= {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      out_r.dot_sum <= {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= issue;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r && s2_tag_r.lastc;
      out_v_r <= s3_v_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
